### design/ppr_pkg.sv
// Shared types, format codes and channel expansion helpers for the RGBA premultiply pipe.
package ppr_pkg;

  localparam int unsigned FmtW = 3;

  typedef enum logic [FmtW-1:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_BGRA8888 = 3'd1,
    FMT_RGB565   = 3'd2,
    FMT_RGB888   = 3'd3,
    FMT_ALPHA8   = 3'd4
  } fmt_e;

  localparam logic [7:0] AlphaOpaque = 8'd255;

  // Unpacked pixel, before premultiplication
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       err;
  } pix_t;

  // Raw color*alpha products
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [7:0]  alpha;
    logic        err;
  } prod_t;

  // floor(v*255/31) = 8v + floor(7v/31)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0] v7;
    logic [2:0] corr;
    v7   = ({3'b000, v} << 3) - {3'b000, v};
    corr = 3'({2'b00, v7 >= 8'd31}  + {2'b00, v7 >= 8'd62}  + {2'b00, v7 >= 8'd93}
            + {2'b00, v7 >= 8'd124} + {2'b00, v7 >= 8'd155} + {2'b00, v7 >= 8'd186}
            + {2'b00, v7 >= 8'd217});
    return {v, 3'b000} + {5'b00000, corr};
  endfunction

  // floor(v*255/63) = 4v + floor(v/21)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] corr;
    corr = 2'({1'b0, v >= 6'd21} + {1'b0, v >= 6'd42} + {1'b0, v >= 6'd63});
    return {v, 2'b00} + {6'b000000, corr};
  endfunction

endpackage

### design/ppr_pix_if.sv
// Input channel carrying raw source pixel beats.
interface ppr_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

### design/ppr_rgba_if.sv
// Output channel carrying premultiplied RGBA8888 beats.
interface ppr_rgba_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       format_error;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output format_error, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input format_error, output ready);
endinterface

### design/pixel_to_premultiplied_rgba.sv
// Top level: source pixel to premultiplied RGBA8888 converter.
//
// pix_i takes one raw 32-bit pixel beat (byte 0 in bits 7:0) per cycle on a
// valid/ready handshake; rgba_o gives one premultiplied RGBA8888 beat for
// each input beat, in order, plus a format_error flag for unsupported codes.
// The source format is written through cfg_we_i / cfg_wdata_i while idle.
//
// Three register stages: unpack/expand, color*alpha multiply, divide by 255.
// Throughput is one beat per cycle while rgba_o is ready, set by the three
// 8x8 multipliers issuing every cycle.
//
// Reset clears the stage valid bits and sets the format to RGBA8888.
// When the receiver stalls, each stage holds its beat and ready propagates
// back; an empty stage keeps accepting, so the pipe fills up before pix_i
// drops ready. No beat is lost or repeated.
module pixel_to_premultiplied_rgba
  import ppr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [FmtW-1:0] cfg_wdata_i,
  ppr_pix_if.sink         pix_i,
  ppr_rgba_if.source      rgba_o
);

  logic [FmtW-1:0] fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGBA8888;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  logic  s1_valid, s1_ready;
  pix_t  s1_data;
  logic  s2_valid, s2_ready;
  prod_t s2_data;

  ppr_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fmt_i   (fmt_q),
    .valid_i (pix_i.valid),
    .pixel_i (pix_i.source_pixel),
    .ready_o (pix_i.ready),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s1_ready)
  );

  ppr_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s1_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (s2_ready)
  );

  ppr_div255 u_div255 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .ready_o (s2_ready),
    .rgba_o  (rgba_o)
  );

endmodule

### design/ppr_unpack.sv
// Stage 1: decode the pixel word by source format into 8-bit channels.
module ppr_unpack
  import ppr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [FmtW-1:0]     fmt_i,
  input  logic                valid_i,
  input  logic [31:0]         pixel_i,
  output logic                ready_o,
  output logic                valid_o,
  output pix_t                data_o,
  input  logic                ready_i
);

  logic valid_q;
  pix_t data_d, data_q;
  logic [15:0] p565;

  assign p565 = pixel_i[15:0];

  always_comb begin
    data_d = '0;
    unique case (fmt_e'(fmt_i))
      FMT_RGBA8888: begin
        data_d.red   = pixel_i[7:0];
        data_d.green = pixel_i[15:8];
        data_d.blue  = pixel_i[23:16];
        data_d.alpha = pixel_i[31:24];
      end
      FMT_BGRA8888: begin
        data_d.blue  = pixel_i[7:0];
        data_d.green = pixel_i[15:8];
        data_d.red   = pixel_i[23:16];
        data_d.alpha = pixel_i[31:24];
      end
      FMT_RGB565: begin
        data_d.red   = expand5(p565[15:11]);
        data_d.green = expand6(p565[10:5]);
        data_d.blue  = expand5(p565[4:0]);
        data_d.alpha = AlphaOpaque;
      end
      FMT_RGB888: begin
        data_d.red   = pixel_i[7:0];
        data_d.green = pixel_i[15:8];
        data_d.blue  = pixel_i[23:16];
        data_d.alpha = AlphaOpaque;
      end
      FMT_ALPHA8: begin
        data_d.red   = pixel_i[7:0];
        data_d.green = pixel_i[7:0];
        data_d.blue  = pixel_i[7:0];
        data_d.alpha = pixel_i[7:0];
      end
      default: begin
        // unsupported code: all channels zero, flag set
        data_d.err = 1'b1;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/ppr_mult.sv
// Stage 2: multiply each color channel by alpha.
module ppr_mult
  import ppr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  pix_t  data_i,
  output logic  ready_o,
  output logic  valid_o,
  output prod_t data_o,
  input  logic  ready_i
);

  logic  valid_q;
  prod_t data_d, data_q;

  always_comb begin
    data_d.red   = 16'(data_i.red)   * 16'(data_i.alpha);
    data_d.green = 16'(data_i.green) * 16'(data_i.alpha);
    data_d.blue  = 16'(data_i.blue)  * 16'(data_i.alpha);
    data_d.alpha = data_i.alpha;
    data_d.err   = data_i.err;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/ppr_div255.sv
// Stage 3: divide products by 255 and hold the output beat.
module ppr_div255
  import ppr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  prod_t             data_i,
  output logic              ready_o,
  ppr_rgba_if.source        rgba_o
);

  logic valid_q;
  pix_t data_d, data_q;

  // floor(x/255) = (x + 1 + (x >> 8)) >> 8, exact for every 8x8 product (x <= 65025)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

  always_comb begin
    data_d.red   = div255(data_i.red);
    data_d.green = div255(data_i.green);
    data_d.blue  = div255(data_i.blue);
    data_d.alpha = data_i.alpha;
    data_d.err   = data_i.err;
  end

  assign ready_o = !valid_q || rgba_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign rgba_o.valid        = valid_q;
  assign rgba_o.red_out      = data_q.red;
  assign rgba_o.green_out    = data_q.green;
  assign rgba_o.blue_out     = data_q.blue;
  assign rgba_o.alpha_out    = data_q.alpha;
  assign rgba_o.format_error = data_q.err;

endmodule

### verif/testbench.sv
// Self-checking testbench for the pixel to premultiplied RGBA8888 converter.
`timescale 1ns / 100ps

module testbench;
  import ppr_pkg::*;

  localparam int unsigned ClkHalf    = 5;
  localparam int unsigned ResetLen   = 6;
  localparam int unsigned PipeDepth  = 3;
  localparam int unsigned LongStall  = 150;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [31:0] DirectedWords [3] = '{32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h7F12_F81F};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [FmtW-1:0] cfg_wdata_i = '0;

  ppr_pix_if  pix_if();
  ppr_rgba_if rgba_if();

  pixel_to_premultiplied_rgba i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .rgba_o      (rgba_if)
  );

  logic [31:0]     pending_pixel_q[$];
  pix_t            expected_rgba_q[$];
  logic [FmtW-1:0] format_shadow = '0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     stall_token = 0;
  int unsigned     stall_seen;
  int unsigned     stall_left;
  int unsigned     cycle_count = 0;
  int unsigned     error_count = 0;
  int unsigned     beats_checked = 0;
  int unsigned     error_beats = 0;

  always #(ClkHalf) clk_i = ~clk_i;

  initial begin
    pix_if.valid        = 1'b0;
    pix_if.source_pixel = '0;
    rgba_if.ready       = 1'b0;
  end

  function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
    return 8'((16'(c) * 16'(a)) / 16'd255);
  endfunction

  function automatic pix_t premultiply_pixel(input logic [31:0] px, input logic [FmtW-1:0] fmt);
    pix_t p;
    p = '0;
    case (fmt)
      FMT_RGBA8888: begin
        p.red = px[7:0]; p.green = px[15:8]; p.blue = px[23:16]; p.alpha = px[31:24];
      end
      FMT_BGRA8888: begin
        p.blue = px[7:0]; p.green = px[15:8]; p.red = px[23:16]; p.alpha = px[31:24];
      end
      FMT_RGB565: begin
        p.red   = 8'((int'(px[15:11]) * 255) / 31);
        p.green = 8'((int'(px[10:5]) * 255) / 63);
        p.blue  = 8'((int'(px[4:0]) * 255) / 31);
        p.alpha = AlphaOpaque;
      end
      FMT_RGB888: begin
        p.red = px[7:0]; p.green = px[15:8]; p.blue = px[23:16]; p.alpha = AlphaOpaque;
      end
      FMT_ALPHA8: begin
        p.red = px[7:0]; p.green = px[7:0]; p.blue = px[7:0]; p.alpha = px[7:0];
      end
      default: p.err = 1'b1;
    endcase
    if (!p.err) begin
      p.red   = scale_by_alpha(p.red, p.alpha);
      p.green = scale_by_alpha(p.green, p.alpha);
      p.blue  = scale_by_alpha(p.blue, p.alpha);
    end
    return p;
  endfunction

  // biased toward alpha and byte extremes
  function automatic logic [31:0] random_pixel();
    logic [31:0] w;
    int unsigned i;
    w = $urandom;
    case ($urandom_range(9))
      0: w[31:24] = 8'h00;
      1: w[31:24] = 8'hFF;
      2: for (i = 0; i < 4; i++) w[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      3: w[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return w;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (pix_if.valid && !pix_if.ready) begin
      // hold the beat until taken
    end else if (pending_pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      pix_if.valid        <= 1'b1;
      pix_if.source_pixel <= pending_pixel_q.pop_front();
    end else begin
      pix_if.valid        <= 1'b0;
      pix_if.source_pixel <= $urandom;
    end
  end

  // receiver, with a long hold-off counted here
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rgba_if.ready <= 1'b0;
      stall_seen    <= 0;
      stall_left    <= 0;
    end else if (stall_seen != stall_token) begin
      stall_seen    <= stall_token;
      stall_left    <= LongStall;
      rgba_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      rgba_if.ready <= 1'b0;
    end else begin
      rgba_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check output beats, then record the input beat accepted on this edge
  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni) begin
      if (rgba_if.valid && rgba_if.ready) begin
        if (expected_rgba_q.size() == 0) begin
          $display("%0t: unexpected beat r=%h g=%h b=%h a=%h err=%b", $time,
                   rgba_if.red_out, rgba_if.green_out, rgba_if.blue_out,
                   rgba_if.alpha_out, rgba_if.format_error);
          error_count <= error_count + 1;
        end else begin
          want = expected_rgba_q.pop_front();
          if (rgba_if.red_out !== want.red || rgba_if.green_out !== want.green ||
              rgba_if.blue_out !== want.blue || rgba_if.alpha_out !== want.alpha ||
              rgba_if.format_error !== want.err) begin
            $display("%0t: mismatch expected r=%h g=%h b=%h a=%h err=%b, got r=%h g=%h b=%h a=%h err=%b",
                     $time, want.red, want.green, want.blue, want.alpha, want.err,
                     rgba_if.red_out, rgba_if.green_out, rgba_if.blue_out,
                     rgba_if.alpha_out, rgba_if.format_error);
            error_count <= error_count + 1;
          end
          beats_checked <= beats_checked + 1;
          if (want.err) error_beats <= error_beats + 1;
        end
      end
      if (pix_if.valid && pix_if.ready)
        expected_rgba_q.push_back(premultiply_pixel(pix_if.source_pixel, format_shadow));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               expected_rgba_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // sampled mid-cycle so the edge updates have all settled
  task automatic wait_drained();
    while (pending_pixel_q.size() > 0 || pix_if.valid || expected_rgba_q.size() > 0)
      @(negedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  task automatic write_source_format(input logic [FmtW-1:0] fmt);
    @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= fmt;
    format_shadow <= fmt;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= $urandom;
  endtask

  initial begin
    int unsigned fmt;
    int unsigned phase;
    int unsigned i;
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: every format code, full and zero alpha, unused bytes set
    for (fmt = 0; fmt < 8; fmt++) begin
      write_source_format(FmtW'(fmt));
      if (fmt == 0) pending_pixel_q.push_back(32'h0000_0000);
      for (i = 0; i < 3; i++) pending_pixel_q.push_back(DirectedWords[i]);
      wait_drained();
    end

    for (phase = 0; phase < 9; phase++) begin
      if (phase < 3) begin
        send_idle_pct <= 16; recv_idle_pct <= 66;
      end else if (phase < 6) begin
        send_idle_pct <= 66; recv_idle_pct <= 16;
      end else begin
        send_idle_pct <= 0;  recv_idle_pct <= 0;
      end
      if (phase == 0)      fmt = 7;
      else if (phase == 8) fmt = 0;
      else if ($urandom_range(4) == 0) fmt = $urandom_range(7, 5);
      else fmt = $urandom_range(4);
      write_source_format(FmtW'(fmt));
      for (i = 0; i < PhaseItems; i++) pending_pixel_q.push_back(random_pixel());
      if (phase == 6) stall_token <= stall_token + 1;  // fill the pipe and back up the input
      wait_drained();
    end

    repeat (PipeDepth * 4) @(posedge clk_i);
    $display("covered %0d output beats across all eight format codes, %0d flagged unsupported",
             beats_checked, error_beats);
    $display("idle mixes on both sides, a long receiver hold-off and drained phase gaps");
    if (error_count == 0 && expected_rgba_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches, %0d beats never seen", error_count, expected_rgba_q.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
